// ----- sv/plg_pkg.sv -----
`timescale 1ns / 1ps

package plg_pkg;

  // frame geometry
  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_W     = 24;
  localparam int GAIN_W       = 32;
  localparam int CHAN_IDX_W   = 3;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_CEILING = 2'd0;
  localparam reg_idx_t REG_RELEASE = 2'd1;
  localparam reg_idx_t REG_COUNT   = 2'd2;

  // reset values
  localparam logic [23:0] CEILING_RESET = 24'd7476355;
  localparam logic [31:0] RELEASE_RESET = 32'd0;
  localparam logic [3:0]  COUNT_RESET   = 4'd2;
  localparam logic [31:0] UNITY_GAIN    = 32'h8000_0000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // control of one scaling lane
  typedef struct packed {
    logic load;
    logic step;
  } lane_ctl_t;

endpackage

// ----- sv/plg_lane.sv -----
`timescale 1ns / 1ps

module plg_lane (
  input  logic               clk,
  input  plg_pkg::lane_ctl_t ctl,
  input  plg_pkg::sample_t   sample,
  input  logic               gain_bit,
  output plg_pkg::sample_t   held,
  output plg_pkg::sample_t   result
);

  plg_pkg::sample_t   mult;
  logic signed [24:0] acc;
  logic               last_bit;
  logic signed [24:0] sum;

  // one gain bit per cycle while step is high, lsb first: add, then shift right arithmetically
  always_comb begin
    sum = acc + (gain_bit ? 25'(mult) : 25'sd0);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mult     <= sample;
      acc      <= '0;
      last_bit <= 1'b0;
    end else if (ctl.step) begin
      acc      <= sum >>> 1;
      last_bit <= sum[0];
    end
  end

  // once all 32 gain bits are in, acc is the product over 2^32 and last_bit its bit 31
  assign result = {acc[22:0], last_bit};
  assign held   = mult;

endmodule

// ----- sv/peak_limiter_gain.sv -----
`timescale 1ns / 1ps

// Peak limiter with a shared gain and instant attack.
// Input channel: in_valid / in_stall with one frame of eight signed Q1.23
// samples; channels at or above channel_count are treated as silent.
// Output channel: out_valid / out_stall with the limited samples and the
// unsigned Q1.31 gain applied to the frame.
// Configuration: APB-style port, ceiling_level at 0x0, release_coef at 0x4,
// channel_count at 0x8; the user must see that they are written only while
// no frame is in flight, as the block itself does not enforce it.
// One frame at a time: in_stall is high from acceptance until the result is
// placed in the output register. A frame goes through the peak search, the
// bit-serial attack test and release multiply, the decision, the restoring
// divide when the gain must drop, the bit-serial scaling of all eight lanes
// and the load of the output. The multipliers and the scaling lanes take one
// bit per cycle of the 32-bit gain or coefficient; the divider forms its
// quotient bit by bit.
// The output register lets the next frame be accepted and processed while
// a result waits; a stalled receiver holds the result and, once the next
// result is ready, holds the block in its final cycle.
// Reset sets unity gain, the register defaults and empties the output.
module peak_limiter_gain (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [plg_pkg::ADDR_W-1:0]  paddr,
  input  logic [plg_pkg::DATA_W-1:0]  pwdata,
  output logic [plg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  // input frames
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [23:0]          sample_0,
  input  logic signed [23:0]          sample_1,
  input  logic signed [23:0]          sample_2,
  input  logic signed [23:0]          sample_3,
  input  logic signed [23:0]          sample_4,
  input  logic signed [23:0]          sample_5,
  input  logic signed [23:0]          sample_6,
  input  logic signed [23:0]          sample_7,
  // output frames
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [23:0]          out_0,
  output logic signed [23:0]          out_1,
  output logic signed [23:0]          out_2,
  output logic signed [23:0]          out_3,
  output logic signed [23:0]          out_4,
  output logic signed [23:0]          out_5,
  output logic signed [23:0]          out_6,
  output logic signed [23:0]          out_7,
  output logic [31:0]                 applied_gain
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEAK,
    ST_MULT,
    ST_DECIDE,
    ST_DIV,
    ST_SCALE,
    ST_WRITE
  } state_t;

  // configuration registers
  logic [23:0] ceiling_level;
  logic [31:0] release_coef;
  logic [3:0]  channel_count;

  state_t      state;
  logic [4:0]  cnt;
  logic [31:0] current_gain;

  // peak search
  logic [22:0] peak;

  // attack test multiply: peak * gain
  logic [31:0] mq;
  logic [22:0] tacc;
  logic [31:0] tlo;

  // release multiply: (unity - gain) * coef
  logic [31:0] rq;
  logic [31:0] racc;
  logic [31:0] rd;

  // restoring divide: (ceiling << 31) / peak
  logic [22:0] drem;
  logic [31:0] dq;

  // gain bits for the scaling lanes
  logic [31:0] gsh;

  // output register
  plg_pkg::sample_t out_d [plg_pkg::MAX_CHANNELS];

  // lanes
  plg_pkg::sample_t   samp_in [plg_pkg::MAX_CHANNELS];
  plg_pkg::sample_t   samp_ld [plg_pkg::MAX_CHANNELS];
  plg_pkg::sample_t   held    [plg_pkg::MAX_CHANNELS];
  plg_pkg::sample_t   lane_y  [plg_pkg::MAX_CHANNELS];
  plg_pkg::lane_ctl_t lane_ctl;

  logic        in_acc;
  logic        out_free;
  logic        cfg_wr;
  logic [3:0]  n_act;
  logic [plg_pkg::MAX_CHANNELS-1:0] active;
  logic [22:0] peak_cand;
  logic [23:0] tsum;
  logic [32:0] rsum;
  logic [23:0] dsh;
  logic        dge;
  logic [23:0] ddiff;
  logic [31:0] dq_next;
  logic        cut;
  logic [31:0] rel_gain;

  function automatic logic [22:0] abs_sat(input plg_pkg::sample_t s);
    logic [23:0] neg;
    neg = 24'(-s);
    if (!s[23]) begin
      abs_sat = s[22:0];
    end else if (neg[23]) begin
      abs_sat = 23'h7F_FFFF;
    end else begin
      abs_sat = neg[22:0];
    end
  endfunction

  assign samp_in[0] = sample_0;
  assign samp_in[1] = sample_1;
  assign samp_in[2] = sample_2;
  assign samp_in[3] = sample_3;
  assign samp_in[4] = sample_4;
  assign samp_in[5] = sample_5;
  assign samp_in[6] = sample_6;
  assign samp_in[7] = sample_7;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling_level <= plg_pkg::CEILING_RESET;
      release_coef  <= plg_pkg::RELEASE_RESET;
      channel_count <= plg_pkg::COUNT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        plg_pkg::REG_CEILING: ceiling_level <= pwdata[23:0];
        plg_pkg::REG_RELEASE: release_coef  <= pwdata;
        plg_pkg::REG_COUNT:   channel_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      plg_pkg::REG_CEILING: prdata = {8'd0, ceiling_level};
      plg_pkg::REG_RELEASE: prdata = release_coef;
      plg_pkg::REG_COUNT:   prdata = {28'd0, channel_count};
      default:              prdata = '0;
    endcase
  end

  // active channel mask, count saturated to the channel total
  always_comb begin
    n_act = (channel_count > 4'(plg_pkg::MAX_CHANNELS)) ?
            4'(plg_pkg::MAX_CHANNELS) : channel_count;
    for (int c = 0; c < plg_pkg::MAX_CHANNELS; c++) begin
      active[c]  = (4'(c) < n_act);
      samp_ld[c] = active[c] ? samp_in[c] : '0;
    end
  end

  // scaling lanes
  assign lane_ctl.load = in_acc;
  assign lane_ctl.step = (state == ST_SCALE);

  for (genvar c = 0; c < plg_pkg::MAX_CHANNELS; c++) begin : g_lane
    plg_lane u_lane (
      .clk      (clk),
      .ctl      (lane_ctl),
      .sample   (samp_ld[c]),
      .gain_bit (gsh[0]),
      .held     (held[c]),
      .result   (lane_y[c])
    );
  end

  // serial datapath steps
  always_comb begin
    peak_cand = abs_sat(held[cnt[plg_pkg::CHAN_IDX_W-1:0]]);
    tsum      = {1'b0, tacc} + (mq[0] ? {1'b0, peak} : 24'd0);
    rsum      = {1'b0, racc} + (rq[0] ? {1'b0, rd} : 33'd0);
    dsh       = {drem, (cnt == 5'd0) ? ceiling_level[0] : 1'b0};
    dge       = (dsh >= {1'b0, peak});
    ddiff     = dsh - {1'b0, peak};
    dq_next   = {dq[30:0], dge};
    cut       = ({tacc, tlo} > {ceiling_level, 31'd0});
    rel_gain  = current_gain + racc;
  end

  // sequencer and serial units
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      current_gain <= plg_pkg::UNITY_GAIN;
      out_valid    <= 1'b0;
    end else begin
      // result taken, and no new one loaded in its place
      if (out_valid && !out_stall && state != ST_WRITE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            peak  <= '0;
            mq    <= current_gain;
            tacc  <= '0;
            tlo   <= '0;
            rq    <= release_coef;
            racc  <= '0;
            rd    <= plg_pkg::UNITY_GAIN - current_gain;
            cnt   <= '0;
            state <= ST_PEAK;
          end
        end
        // one channel per cycle
        ST_PEAK: begin
          if (peak_cand > peak) begin
            peak <= peak_cand;
          end
          if (cnt == 5'(plg_pkg::MAX_CHANNELS - 1)) begin
            cnt   <= '0;
            state <= ST_MULT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        // attack test and release step, one multiplier bit per cycle
        ST_MULT: begin
          tacc <= tsum[23:1];
          tlo  <= {tsum[0], tlo[31:1]};
          mq   <= mq >> 1;
          racc <= rsum[32:1];
          rq   <= rq >> 1;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          cnt <= '0;
          if (cut) begin
            drem  <= ceiling_level[23:1];
            dq    <= '0;
            state <= ST_DIV;
          end else begin
            current_gain <= rel_gain;
            gsh          <= rel_gain;
            state        <= ST_SCALE;
          end
        end
        // one quotient bit per cycle, count wraps to zero at the end
        ST_DIV: begin
          drem <= dge ? ddiff[22:0] : dsh[22:0];
          dq   <= dq_next;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            current_gain <= dq_next;
            gsh          <= dq_next;
            state        <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          gsh <= gsh >> 1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            for (int c = 0; c < plg_pkg::MAX_CHANNELS; c++) begin
              out_d[c] <= lane_y[c];
            end
            applied_gain <= current_gain;
            out_valid    <= 1'b1;
            cnt          <= '0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_0 = out_d[0];
  assign out_1 = out_d[1];
  assign out_2 = out_d[2];
  assign out_3 = out_d[3];
  assign out_4 = out_d[4];
  assign out_5 = out_d[5];
  assign out_6 = out_d[6];
  assign out_7 = out_d[7];

  // gain never rises above unity
  a_gain_max: assert property (@(posedge clk) disable iff (rst)
    current_gain <= plg_pkg::UNITY_GAIN)
    else $error("gain above unity");

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> {1'b0, drem} < {1'b0, peak})
    else $error("divider remainder not below peak");

  // a fresh result carries the held gain
  a_gain_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> applied_gain == current_gain)
    else $error("applied gain differs from held gain");

  // work starts only on an accepted item
  a_start: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && !in_acc |=> state == ST_IDLE)
    else $error("sequencer left idle without an item");

endmodule

// ----- tb/peak_limiter_gain_tb.sv -----
`timescale 1ns / 1ps

module peak_limiter_gain_tb;

  localparam int               IDLE_LIMIT = 20000;
  localparam int               DRAIN_WAIT = 120;
  localparam int               HOLD_LEN   = 1500;
  localparam int               RAND_PHASES = 10;
  localparam int               PHASE_FRAMES = 112;
  localparam plg_pkg::sample_t POS_FULL = 24'sh7FFFFF;
  localparam plg_pkg::sample_t NEG_FULL = 24'sh800000;

  // tracks the shared gain and queues the limited frames still to come
  class limiter_checker;
    typedef struct {
      plg_pkg::sample_t smp[plg_pkg::MAX_CHANNELS];
      logic [31:0]      gain;
    } limited_frame_t;

    logic [23:0]     ceiling;
    logic [31:0]     coef;
    logic [3:0]      count;
    logic [31:0]     gain;
    limited_frame_t  frames_due[$];
    int unsigned     errors;
    int unsigned     frame_no;

    function new();
      ceiling  = plg_pkg::CEILING_RESET;
      coef     = plg_pkg::RELEASE_RESET;
      count    = plg_pkg::COUNT_RESET;
      gain     = plg_pkg::UNITY_GAIN;
      errors   = 0;
      frame_no = 0;
    endfunction

    function void set_reg(plg_pkg::reg_idx_t idx, logic [31:0] val);
      case (idx)
        plg_pkg::REG_CEILING: ceiling = val[23:0];
        plg_pkg::REG_RELEASE: coef = val;
        plg_pkg::REG_COUNT:   count = val[3:0];
        default: ;
      endcase
    endfunction

    // peak search, attack or release, then scaling of the active lanes
    function void take_frame(plg_pkg::sample_t smp[plg_pkg::MAX_CHANNELS]);
      limited_frame_t want;
      int             n;
      int             c;
      longint         sv;
      longint         prod;
      logic [63:0]    mag;
      logic [63:0]    peak;
      logic [63:0]    ceil_scaled;
      logic [63:0]    g;
      n = (count > plg_pkg::MAX_CHANNELS) ? plg_pkg::MAX_CHANNELS : int'(count);
      peak = 0;
      for (c = 0; c < n; c++) begin
        sv = smp[c];
        mag = (sv < 0) ? 64'(-sv) : 64'(sv);
        if (mag > 64'h7FFFFF) mag = 64'h7FFFFF;
        if (mag > peak) peak = mag;
      end
      ceil_scaled = {9'b0, ceiling, 31'b0};
      g = {32'b0, gain};
      if (peak * g > ceil_scaled) begin
        g = ceil_scaled / peak;
      end else begin
        g = g + (((64'h8000_0000 - g) * {32'b0, coef}) >> 32);
      end
      gain = g[31:0];
      for (c = 0; c < plg_pkg::MAX_CHANNELS; c++) begin
        if (c < n) begin
          prod = longint'(smp[c]) * longint'(g);
          prod = prod >>> 31;
          want.smp[c] = prod[23:0];
        end else begin
          want.smp[c] = '0;
        end
      end
      want.gain = gain;
      frames_due.push_back(want);
    endfunction

    function void note_error(string field, longint exp_v, longint got_v);
      errors++;
      if (errors <= 10)
        $display("mismatch frame %0d %s: expected %0d got %0d", frame_no, field, exp_v, got_v);
    endfunction

    function void check_frame(plg_pkg::sample_t got[plg_pkg::MAX_CHANNELS],
                              logic [31:0] got_gain);
      limited_frame_t want;
      int             c;
      if (frames_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result with no frame pending");
        return;
      end
      want = frames_due.pop_front();
      for (c = 0; c < plg_pkg::MAX_CHANNELS; c++) begin
        if (got[c] !== want.smp[c])
          note_error($sformatf("out_%0d", c), want.smp[c], got[c]);
      end
      if (got_gain !== want.gain)
        note_error("applied_gain", want.gain, got_gain);
      frame_no++;
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [plg_pkg::ADDR_W-1:0]  paddr = '0;
  logic [plg_pkg::DATA_W-1:0]  pwdata = '0;
  logic [plg_pkg::DATA_W-1:0]  prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  plg_pkg::sample_t            sample_0 = '0, sample_1 = '0, sample_2 = '0, sample_3 = '0;
  plg_pkg::sample_t            sample_4 = '0, sample_5 = '0, sample_6 = '0, sample_7 = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  plg_pkg::sample_t            out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7;
  logic [31:0]                 applied_gain;

  limiter_checker              sb = new();
  plg_pkg::sample_t            frame_buf[plg_pkg::MAX_CHANNELS];
  plg_pkg::sample_t            got_frame[plg_pkg::MAX_CHANNELS];
  bit                          tx_idle_on = 1'b0;
  bit                          rx_idle_on = 1'b0;
  int                          rx_hold_req = 0;
  int                          rx_left = 0;
  int                          quiet_cycles = 0;

  peak_limiter_gain dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2), .sample_3(sample_3),
    .sample_4(sample_4), .sample_5(sample_5), .sample_6(sample_6), .sample_7(sample_7),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_0(out_0), .out_1(out_1), .out_2(out_2), .out_3(out_3),
    .out_4(out_4), .out_5(out_5), .out_6(out_6), .out_7(out_7),
    .applied_gain(applied_gain)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  function automatic plg_pkg::sample_t rand_sample(int lvl);
    logic [31:0] r;
    r = $urandom();
    case (lvl)
      0: return r[23:0];
      1: return 24'($signed(r[13:0]));
      2: return 24'($signed(r[22:0]));
      default: begin
        case (r[26:24] % 6)
          0: return NEG_FULL;
          1: return POS_FULL;
          2: return -POS_FULL;
          3: return 24'sd0;
          4: return 24'sd1;
          default: return -24'sd1;
        endcase
      end
    endcase
  endfunction

  // receiver: check each accepted result, then choose the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_frame = '{out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7};
      sb.check_frame(got_frame, applied_gain);
    end
    if (rx_hold_req > 0) begin
      rx_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_left > 0) begin
      out_stall <= 1'b1;
      rx_left--;
    end else begin
      out_stall <= 1'b0;
      rx_left = pick_gap(rx_idle_on);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_frame(plg_pkg::sample_t f[plg_pkg::MAX_CHANNELS]);
    int gap;
    in_valid <= 1'b1;
    sample_0 <= f[0]; sample_1 <= f[1]; sample_2 <= f[2]; sample_3 <= f[3];
    sample_4 <= f[4]; sample_5 <= f[5]; sample_6 <= f[6]; sample_7 <= f[7];
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.take_frame(f);
    gap = pick_gap(tx_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // setup cycle, access cycle, then an idle cycle before the next write
  task automatic write_reg(plg_pkg::reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every frame has come back and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic setup(logic [31:0] ceil_v, logic [31:0] coef_v, logic [31:0] cnt_v);
    drain();
    write_reg(plg_pkg::REG_CEILING, ceil_v);
    write_reg(plg_pkg::REG_RELEASE, coef_v);
    write_reg(plg_pkg::REG_COUNT, cnt_v);
  endtask

  task automatic send_uniform(plg_pkg::sample_t v);
    frame_buf = '{default: v};
    send_frame(frame_buf);
  endtask

  task automatic send_random(int n);
    int i;
    int c;
    int lvl;
    for (i = 0; i < n; i++) begin
      lvl = $urandom_range(0, 9);
      lvl = (lvl < 4) ? 0 : (lvl < 6) ? 1 : (lvl < 8) ? 2 : 3;
      for (c = 0; c < plg_pkg::MAX_CHANNELS; c++) frame_buf[c] = rand_sample(lvl);
      send_frame(frame_buf);
    end
  endtask

  task automatic random_setup();
    logic [31:0] junk;
    logic [23:0] ceil_v;
    logic [31:0] coef_v;
    logic [3:0]  cnt_v;
    junk = $urandom();
    case ($urandom_range(0, 7))
      0: ceil_v = 24'd0;
      1: ceil_v = 24'd8389;
      2: ceil_v = 24'd8388608;
      3: ceil_v = 24'hFFFFFF;
      default: ceil_v = 24'($urandom_range(8389, 8388608));
    endcase
    case ($urandom_range(0, 5))
      0: coef_v = 32'd0;
      1: coef_v = 32'hFFFF_FFFF;
      2: coef_v = $urandom_range(0, 32'h00FF_FFFF);
      default: coef_v = $urandom();
    endcase
    cnt_v = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
    setup({junk[31:24], ceil_v}, coef_v, {junk[31:4], cnt_v});
  endtask

  initial begin
    int p;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: silence, full scale, negative full scale, tiny values
    send_uniform(24'sd0);
    send_uniform(POS_FULL);
    send_uniform(NEG_FULL);
    frame_buf = '{default: 24'sd0};
    frame_buf[0] = 24'sd1;
    frame_buf[1] = -24'sd1;
    send_frame(frame_buf);

    // all eight lanes, ceiling at full scale, fastest release
    setup(32'd8388608, 32'hFFFF_FFFF, 32'd8);
    frame_buf = '{default: 24'sd0};
    frame_buf[7] = NEG_FULL;
    send_frame(frame_buf);
    for (p = 0; p < plg_pkg::MAX_CHANNELS; p++) frame_buf[p] = p[0] ? NEG_FULL : POS_FULL;
    send_frame(frame_buf);
    send_uniform(24'sd0);
    send_random(1);

    // zero ceiling, count above the lane limit
    setup(32'd0, 32'd12345, 32'd15);
    send_random(1);
    send_uniform(24'sd0);
    send_uniform(24'sd0);
    send_random(1);

    // no active lane: outputs zero, gain only releases
    setup(32'd8389, 32'h8000_0000, 32'd0);
    send_uniform(POS_FULL);
    send_random(1);

    // one lane, smallest ceiling in range
    setup(32'd8389, 32'h0000_1000, 32'd1);
    send_uniform(POS_FULL);
    frame_buf = '{default: 24'sd0};
    frame_buf[0] = -24'sd1;
    send_frame(frame_buf);
    frame_buf[1] = NEG_FULL;
    send_frame(frame_buf);

    // receiver holds off while frames keep coming
    setup(32'd7476355, 32'h0100_0000, 32'd8);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random(2);
    rx_hold_req = HOLD_LEN;
    send_random(28);

    // random phases with random settings and idling
    for (p = 0; p < RAND_PHASES; p++) begin
      random_setup();
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      send_random(PHASE_FRAMES);
    end

    drain();
    if (sb.errors == 0 && sb.frames_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- peak_limiter_gain.f -----
sv/plg_pkg.sv
sv/plg_lane.sv
sv/peak_limiter_gain.sv
tb/peak_limiter_gain_tb.sv
